FILE: hw/rtl/cfc_pkg.sv
`timescale 1ns / 1ps

package cfc_pkg;

  // Register index codes (byte address is four times the index)
  localparam logic [2:0] REG_HEADER   = 3'd0;
  localparam logic [2:0] REG_TAIL     = 3'd1;
  localparam logic [2:0] REG_ADDRESS  = 3'd2;
  localparam logic [2:0] REG_UPGRADE  = 3'd3;
  localparam logic [2:0] REG_RUN_MODE = 3'd4;
  localparam logic [2:0] REG_ERASE    = 3'd5;
  localparam logic [2:0] REG_TRANSFER = 3'd6;

  localparam int unsigned ADDR_W = 5;

  // Parser phase: the byte expected next
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ADDR    = 3'd1;
  localparam logic [2:0] PH_BOX     = 3'd2;
  localparam logic [2:0] PH_CMD     = 3'd3;
  localparam logic [2:0] PH_LEN     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;
  localparam logic [2:0] PH_TAIL    = 3'd7;

  // Verdict codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_ADDRESS  = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_TAIL     = 3'd5;

  localparam logic [7:0] BCAST_LOW  = 8'h00;
  localparam logic [7:0] BCAST_HIGH = 8'hFF;
  localparam logic [7:0] ERASE_LEN  = 8'h0E;
  localparam logic [7:0] SHORT_LEN  = 8'h01;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
    logic [7:0] unit_address;
    logic [7:0] upgrade_code;
    logic [7:0] run_mode_code;
    logic [7:0] erase_code;
    logic [7:0] transfer_code;
  } cfc_cfg_t;

  // First matching code decides: upgrade, run mode, erase, transfer
  function automatic logic length_fits(input cfc_cfg_t cfg, input logic [7:0] cmd,
                                       input logic [7:0] len);
    logic fits;
    if (cmd == cfg.upgrade_code || cmd == cfg.run_mode_code) begin
      fits = (len == SHORT_LEN);
    end else if (cmd == cfg.erase_code) begin
      fits = (len == ERASE_LEN);
    end else if (cmd == cfg.transfer_code) begin
      fits = 1'b1;
    end else begin
      fits = 1'b0;
    end
    return fits;
  endfunction

endpackage

FILE: hw/rtl/cfc_regs.sv
`timescale 1ns / 1ps

module cfc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cfc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output cfc_pkg::cfc_cfg_t           cfg
);

  cfc_pkg::cfc_cfg_t cfg_r;
  cfc_pkg::cfc_cfg_t cfg_nxt;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Decode the write beat; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        cfc_pkg::REG_HEADER:   cfg_nxt.header_byte   = cfg_pwdata[7:0];
        cfc_pkg::REG_TAIL:     cfg_nxt.tail_byte     = cfg_pwdata[7:0];
        cfc_pkg::REG_ADDRESS:  cfg_nxt.unit_address  = cfg_pwdata[7:0];
        cfc_pkg::REG_UPGRADE:  cfg_nxt.upgrade_code  = cfg_pwdata[7:0];
        cfc_pkg::REG_RUN_MODE: cfg_nxt.run_mode_code = cfg_pwdata[7:0];
        cfc_pkg::REG_ERASE:    cfg_nxt.erase_code    = cfg_pwdata[7:0];
        cfc_pkg::REG_TRANSFER: cfg_nxt.transfer_code = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    cfg_prdata = 32'd0;
    unique case (reg_idx)
      cfc_pkg::REG_HEADER:   cfg_prdata = {24'd0, cfg_r.header_byte};
      cfc_pkg::REG_TAIL:     cfg_prdata = {24'd0, cfg_r.tail_byte};
      cfc_pkg::REG_ADDRESS:  cfg_prdata = {24'd0, cfg_r.unit_address};
      cfc_pkg::REG_UPGRADE:  cfg_prdata = {24'd0, cfg_r.upgrade_code};
      cfc_pkg::REG_RUN_MODE: cfg_prdata = {24'd0, cfg_r.run_mode_code};
      cfc_pkg::REG_ERASE:    cfg_prdata = {24'd0, cfg_r.erase_code};
      cfc_pkg::REG_TRANSFER: cfg_prdata = {24'd0, cfg_r.transfer_code};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/cfc_parse.sv
`timescale 1ns / 1ps

module cfc_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  cfc_pkg::cfc_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_frame_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_frame_ok,
  output logic [2:0]        out_status
);

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Frame state
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] cmd_r, cmd_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic       ok_r;
  logic [2:0] status_r;

  logic       slot_free;
  logic       proc;
  logic       accept;
  logic       has_res;
  logic [2:0] res_status;
  logic [7:0] left_dec;

  assign slot_free = !out_valid_r || !out_stall;
  assign proc      = s1_valid_r && slot_free;
  assign in_stall  = s1_valid_r && !slot_free;
  assign accept    = in_valid && !in_stall;
  assign left_dec  = left_r - 8'd1;

  // Step the frame parser over the held byte
  always_comb begin
    phase_nxt  = phase_r;
    xor_nxt    = xor_r;
    left_nxt   = left_r;
    cmd_nxt    = cmd_r;
    has_res    = 1'b0;
    res_status = cfc_pkg::ST_OK;
    if (s1_start_r) begin
      xor_nxt  = s1_byte_r;
      left_nxt = 8'd0;
      cmd_nxt  = 8'd0;
      if (s1_byte_r != cfg.header_byte) begin
        has_res    = 1'b1;
        res_status = cfc_pkg::ST_HEADER;
        phase_nxt  = cfc_pkg::PH_IDLE;
      end else begin
        phase_nxt = cfc_pkg::PH_ADDR;
      end
    end else begin
      unique case (phase_r)
        cfc_pkg::PH_IDLE: ;
        cfc_pkg::PH_ADDR: begin
          xor_nxt = xor_r ^ s1_byte_r;
          if (s1_byte_r != cfg.unit_address && s1_byte_r != cfc_pkg::BCAST_LOW &&
              s1_byte_r != cfc_pkg::BCAST_HIGH) begin
            has_res    = 1'b1;
            res_status = cfc_pkg::ST_ADDRESS;
            phase_nxt  = cfc_pkg::PH_IDLE;
          end else begin
            phase_nxt = cfc_pkg::PH_BOX;
          end
        end
        cfc_pkg::PH_BOX: begin
          xor_nxt   = xor_r ^ s1_byte_r;
          phase_nxt = cfc_pkg::PH_CMD;
        end
        cfc_pkg::PH_CMD: begin
          xor_nxt   = xor_r ^ s1_byte_r;
          cmd_nxt   = s1_byte_r;
          phase_nxt = cfc_pkg::PH_LEN;
        end
        cfc_pkg::PH_LEN: begin
          xor_nxt = xor_r ^ s1_byte_r;
          if (!cfc_pkg::length_fits(cfg, cmd_r, s1_byte_r)) begin
            has_res    = 1'b1;
            res_status = cfc_pkg::ST_LENGTH;
            phase_nxt  = cfc_pkg::PH_IDLE;
          end else begin
            left_nxt  = s1_byte_r;
            phase_nxt = (s1_byte_r == 8'd0) ? cfc_pkg::PH_CHECK : cfc_pkg::PH_PAYLOAD;
          end
        end
        cfc_pkg::PH_PAYLOAD: begin
          xor_nxt  = xor_r ^ s1_byte_r;
          left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = cfc_pkg::PH_CHECK;
          end
        end
        cfc_pkg::PH_CHECK: begin
          if (s1_byte_r != xor_r) begin
            has_res    = 1'b1;
            res_status = cfc_pkg::ST_CHECKSUM;
            phase_nxt  = cfc_pkg::PH_IDLE;
          end else begin
            phase_nxt = cfc_pkg::PH_TAIL;
          end
        end
        cfc_pkg::PH_TAIL: begin
          has_res    = 1'b1;
          res_status = (s1_byte_r == cfg.tail_byte) ? cfc_pkg::ST_OK : cfc_pkg::ST_TAIL;
          phase_nxt  = cfc_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // Hold the input register until the parser takes it
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Load a verdict, or drop the one just taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc && has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= cfc_pkg::PH_IDLE;
      xor_r       <= 8'd0;
      left_r      <= 8'd0;
      cmd_r       <= 8'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc) begin
        phase_r <= phase_nxt;
        xor_r   <= xor_nxt;
        left_r  <= left_nxt;
        cmd_r   <= cmd_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
    if (proc && has_res) begin
      ok_r     <= (res_status == cfc_pkg::ST_OK);
      status_r <= res_status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_frame_ok = ok_r;
  assign out_status   = status_r;

  // A verdict returns the parser to idle
  a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && has_res) |=> (phase_r == cfc_pkg::PH_IDLE))
    else $error("parser not idle after verdict");

  // The ok flag agrees with the status code
  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ok_r == (status_r == cfc_pkg::ST_OK)))
    else $error("frame_ok disagrees with status");

  // Only defined status codes leave the block
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r <= cfc_pkg::ST_TAIL))
    else $error("undefined status code");

  // Payload phase always has bytes outstanding
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cfc_pkg::PH_PAYLOAD) |-> (left_r != 8'd0))
    else $error("payload phase with zero bytes left");

  // Input is held back only when a byte is waiting for the result slot
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");

endmodule

FILE: hw/rtl/command_frame_checker.sv
`timescale 1ns / 1ps

// Byte-serial checker for XOR-checked command frames (header, address, box,
// command, length, payload, check byte, tail). One byte beat is taken per
// clock while in_stall is low; each byte is captured in an input register
// and judged by the parser once the result slot is free, and a deciding
// byte's verdict is loaded into the result register, where it waits for
// the result port. At most one verdict per frame, given at the first failing
// byte or at the tail. The input register and the single result register let
// bytes stream at one per cycle; the input stalls only when a byte is held and
// the result port is stalled with a verdict pending. Registers (8 bits each,
// at byte addresses 0x00..0x18): header, tail, unit address, upgrade, run
// mode, erase and transfer codes. Write them only while no frame is in flight.
module command_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_frame_ok,
  output logic [2:0]                  out_status,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cfc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  cfc_pkg::cfc_cfg_t cfg;

  cfc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cfc_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_ok   (out_frame_ok),
    .out_status     (out_status)
  );

endmodule

FILE: test/tb_command_frame_checker.sv
`timescale 1ns / 1ps

module tb_command_frame_checker;
  import cfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES = 300;
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_beat_t;

  typedef struct packed {
    logic       frame_ok;
    logic [2:0] status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_frame_ok;
  logic [2:0] out_status;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state and its copy of the registers
  cfc_cfg_t cfg_model = '0;
  logic [2:0] parse_at = PH_IDLE;
  logic [7:0] frame_xor = 8'h00;
  logic [7:0] payload_owed = 8'h00;
  logic [7:0] cmd_held = 8'h00;

  rx_beat_t rx_pending[$];
  verdict_t verdicts_due[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned cycle_count = 0;
  int in_gap = 0;
  int out_gap = 0;
  int gap_odds = 4;
  int stall_odds = 4;
  bit quiet_tail = 1'b0;
  bit failed = 1'b0;

  command_frame_checker u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_ok   (out_frame_ok),
    .out_status     (out_status),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the parser by one accepted byte and record any verdict it gives
  task automatic judge_byte(input logic [7:0] b, input logic start);
    logic give;
    logic fits;
    logic [2:0] code;
    verdict_t v;
    give = 1'b0;
    code = ST_OK;
    if (start) begin
      frame_xor = b;
      payload_owed = 8'h00;
      cmd_held = 8'h00;
      if (b != cfg_model.header_byte) begin
        give = 1'b1;
        code = ST_HEADER;
      end else begin
        parse_at = PH_ADDR;
      end
    end else begin
      case (parse_at)
        PH_ADDR: begin
          frame_xor ^= b;
          if (b != cfg_model.unit_address && b != BCAST_LOW && b != BCAST_HIGH) begin
            give = 1'b1;
            code = ST_ADDRESS;
          end else begin
            parse_at = PH_BOX;
          end
        end
        PH_BOX: begin
          frame_xor ^= b;
          parse_at = PH_CMD;
        end
        PH_CMD: begin
          frame_xor ^= b;
          cmd_held = b;
          parse_at = PH_LEN;
        end
        PH_LEN: begin
          frame_xor ^= b;
          // later tests override earlier ones, so upgrade and run mode win
          fits = 1'b0;
          if (cmd_held == cfg_model.transfer_code) fits = 1'b1;
          if (cmd_held == cfg_model.erase_code) fits = (b == ERASE_LEN);
          if (cmd_held == cfg_model.upgrade_code || cmd_held == cfg_model.run_mode_code)
            fits = (b == SHORT_LEN);
          if (!fits) begin
            give = 1'b1;
            code = ST_LENGTH;
          end else begin
            payload_owed = b;
            parse_at = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          frame_xor ^= b;
          payload_owed = payload_owed - 8'd1;
          if (payload_owed == 8'h00) parse_at = PH_CHECK;
        end
        PH_CHECK: begin
          if (b != frame_xor) begin
            give = 1'b1;
            code = ST_CHECKSUM;
          end else begin
            parse_at = PH_TAIL;
          end
        end
        PH_TAIL: begin
          give = 1'b1;
          code = (b == cfg_model.tail_byte) ? ST_OK : ST_TAIL;
        end
        default: ;
      endcase
    end
    if (give) begin
      parse_at = PH_IDLE;
      v.frame_ok = (code == ST_OK);
      v.status = code;
      verdicts_due.push_back(v);
    end
  endtask

  task automatic push_beat(input logic [7:0] b, input logic start);
    rx_beat_t beat;
    beat.rx_byte = b;
    beat.frame_start = start;
    rx_pending.push_back(beat);
    bytes_queued++;
  endtask

  // Build a frame with the current header; keep only its first bytes if asked
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [7:0] len, input logic [7:0] check_flip,
                             input logic [7:0] tail, input int keep);
    logic [7:0] body[$];
    logic [7:0] acc;
    body.push_back(cfg_model.header_byte);
    body.push_back(addr);
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(cmd);
    body.push_back(len);
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
    acc = 8'h00;
    foreach (body[k]) acc ^= body[k];
    body.push_back(acc ^ check_flip);
    body.push_back(tail);
    foreach (body[k]) begin
      if (k < keep) push_beat(body[k], k == 0);
    end
  endtask

  task automatic queue_random_frame();
    int pick;
    int keep;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] flip;
    logic [7:0] tail;
    // stray bytes between frames
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
    if ($urandom_range(0, 24) == 0) begin
      push_beat(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    pick = $urandom_range(0, 11);
    if (pick < 4) addr = cfg_model.unit_address;
    else if (pick < 7) addr = BCAST_LOW;
    else if (pick < 10) addr = BCAST_HIGH;
    else begin
      do addr = 8'($urandom_range(0, 255));
      while (addr == cfg_model.unit_address || addr == BCAST_LOW || addr == BCAST_HIGH);
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      cmd = cfg_model.upgrade_code;
      len = SHORT_LEN;
    end else if (pick < 4) begin
      cmd = cfg_model.run_mode_code;
      len = SHORT_LEN;
    end else if (pick < 6) begin
      cmd = cfg_model.erase_code;
      len = ERASE_LEN;
    end else if (pick < 9) begin
      cmd = cfg_model.transfer_code;
      if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(9, 255));
      else len = 8'($urandom_range(0, 8));
    end else begin
      do cmd = 8'($urandom_range(0, 255));
      while (cmd == cfg_model.upgrade_code || cmd == cfg_model.run_mode_code ||
             cmd == cfg_model.erase_code || cmd == cfg_model.transfer_code);
      len = 8'($urandom_range(0, 15));
    end
    if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(0, 15));
    flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    tail = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : cfg_model.tail_byte;
    keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 6 + int'(len)) : 1000;
    queue_frame(addr, cmd, len, flip, tail, keep);
  endtask

  // APB write: setup beat, then access beat until pready
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    cfg_pwdata <= {24'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_HEADER:   cfg_model.header_byte = value;
      REG_TAIL:     cfg_model.tail_byte = value;
      REG_ADDRESS:  cfg_model.unit_address = value;
      REG_UPGRADE:  cfg_model.upgrade_code = value;
      REG_RUN_MODE: cfg_model.run_mode_code = value;
      REG_ERASE:    cfg_model.erase_code = value;
      REG_TRANSFER: cfg_model.transfer_code = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfc_cfg_t s);
    write_reg(REG_HEADER, s.header_byte);
    write_reg(REG_TAIL, s.tail_byte);
    write_reg(REG_ADDRESS, s.unit_address);
    write_reg(REG_UPGRADE, s.upgrade_code);
    write_reg(REG_RUN_MODE, s.run_mode_code);
    write_reg(REG_ERASE, s.erase_code);
    write_reg(REG_TRANSFER, s.transfer_code);
    // the spare slot holds no register
    write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
  endtask

  // Wait until every byte is taken and every verdict seen, then let the pipe empty
  task automatic settle();
    do @(negedge clk); while (bytes_taken != bytes_queued || verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cfc_cfg_t random_settings();
    cfc_cfg_t s;
    s.header_byte = 8'($urandom_range(0, 255));
    s.tail_byte = 8'($urandom_range(0, 255));
    s.unit_address = 8'($urandom_range(0, 255));
    s.upgrade_code = 8'($urandom_range(0, 255));
    s.run_mode_code = 8'($urandom_range(0, 255));
    s.erase_code = 8'($urandom_range(0, 255));
    s.transfer_code = 8'($urandom_range(0, 255));
    return s;
  endfunction

  // Feed byte beats from the pending queue, predicting each accepted one
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      judge_byte(in_rx_byte, in_frame_start);
      bytes_taken++;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
        in_gap = $urandom_range(1, 19) - 1;
        in_valid <= 1'b0;
      end else if (rx_pending.size() != 0) begin
        rx_beat_t beat;
        beat = rx_pending.pop_front();
        in_valid <= 1'b1;
        in_rx_byte <= beat.rx_byte;
        in_frame_start <= beat.frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Hold off the result port in bursts
  always @(posedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && stall_odds != 0 &&
                 $urandom_range(0, stall_odds - 1) == 0) begin
      out_gap = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each verdict beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict: frame_ok %0d status %0d", out_frame_ok, out_status);
        failed = 1'b1;
      end else begin
        verdict_t want;
        want = verdicts_due.pop_front();
        if (out_frame_ok !== want.frame_ok) begin
          $error("frame_ok: expected %0d, got %0d", want.frame_ok, out_frame_ok);
          failed = 1'b1;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_command_frame_checker failed");
      $finish;
    end
  end

  initial begin
    cfc_cfg_t s;
    logic [7:0] code;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: distinct codes, short frames around each check
    s.header_byte = 8'hA5;
    s.tail_byte = 8'h5A;
    s.unit_address = 8'h12;
    s.upgrade_code = 8'h01;
    s.run_mode_code = 8'h02;
    s.erase_code = 8'h03;
    s.transfer_code = 8'h04;
    apply_settings(s);
    push_beat(8'h3C, 1'b0);
    push_beat(8'h00, 1'b1);
    queue_frame(8'h33, 8'h01, 8'h01, 8'h00, 8'h5A, 2);
    queue_frame(8'hFF, 8'h01, 8'h02, 8'h00, 8'h5A, 5);
    queue_frame(8'h00, 8'h02, 8'h01, 8'h00, 8'h5A, 2);
    queue_frame(8'h12, 8'h04, 8'h00, 8'h00, 8'h5A, 1000);
    queue_frame(8'h12, 8'h03, 8'h01, 8'h00, 8'h5A, 5);
    queue_frame(8'h00, 8'hEE, 8'h01, 8'h00, 8'h5A, 5);
    settle();

    // Random phases, each under its own register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          s = '0;
          gap_odds = 4;
          stall_odds = 6;
        end
        1: begin
          s = '1;
          gap_odds = 0;
          stall_odds = 0;
        end
        2: begin
          s = random_settings();
          gap_odds = 8;
          stall_odds = 3;
        end
        3: begin
          s = random_settings();
          code = 8'($urandom_range(0, 255));
          s.upgrade_code = code;
          s.run_mode_code = code;
          s.erase_code = code;
          s.transfer_code = code;
          gap_odds = 3;
          stall_odds = 12;
        end
        4: begin
          s = random_settings();
          s.run_mode_code = s.upgrade_code;
          s.transfer_code = s.erase_code;
          gap_odds = 16;
          stall_odds = 16;
        end
        default: begin
          s = random_settings();
          quiet_tail = 1'b1;
        end
      endcase
      apply_settings(s);
      begin
        int unsigned stop_at;
        stop_at = bytes_queued + PHASE_BYTES;
        while (bytes_queued < stop_at) queue_random_frame();
      end
      settle();
    end

    if (verdicts_due.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("tb_command_frame_checker passed");
    end else begin
      $display("tb_command_frame_checker failed");
    end
    $finish;
  end

endmodule
